FILE: src/mpe_pkg.sv
// Shared types and constants of the Mandelbrot pixel engine.
package mpe_pkg;

   localparam int FRAC_BITS    = 28;
   localparam int MAX_SIDE     = 4096;
   localparam int PALETTE_SIZE = 16;

   localparam int POS_W      = 12;
   localparam int SIZE_W     = 13;
   localparam int ITER_W     = 12;
   localparam int COORD_W    = 32;
   localparam int SPAN_W     = 32;
   localparam int QUO_W      = POS_W + SPAN_W;
   localparam int REM_W      = $clog2(MAX_SIDE);
   localparam int Z_W        = 33;
   localparam int SQ_W       = 37;
   localparam int PROD_W     = 2 * Z_W;
   localparam int COLOR_W    = 8;
   localparam int PAL_IDX_W  = $clog2(PALETTE_SIZE);
   localparam int DIV_CNT_W  = $clog2(QUO_W);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [SQ_W:0] ESC_LIMIT = (SQ_W + 1)'(4) << FRAC_BITS;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SCREEN_WIDTH   = 3'd0,
      REG_SCREEN_HEIGHT  = 3'd1,
      REG_MAX_ITERATIONS = 3'd2,
      REG_REAL_MIN       = 3'd3,
      REG_REAL_MAX       = 3'd4,
      REG_IMAG_MIN       = 3'd5,
      REG_IMAG_MAX       = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic [SIZE_W-1:0]  screen_width;
      logic [SIZE_W-1:0]  screen_height;
      logic [ITER_W-1:0]  max_iterations;
      logic [COORD_W-1:0] real_min;
      logic [COORD_W-1:0] real_max;
      logic [COORD_W-1:0] imag_min;
      logic [COORD_W-1:0] imag_max;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic axis;
      logic map_mul;
      logic div_step;
      logic map_done;
      logic iter_a;
      logic iter_b;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic iter_go;
   } status_type;

endpackage

FILE: src/mpe_req_if.sv
// Pixel request channel: valid, ready and pixel coordinates.
interface mpe_req_if
   import mpe_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] pixel_x;
   logic [POS_W-1:0] pixel_y;

   modport source(output valid, pixel_x, pixel_y, input ready);
   modport sink(input valid, pixel_x, pixel_y, output ready);
endinterface

FILE: src/mpe_rsp_if.sv
// Pixel result channel: valid, ready, iteration count, inside flag and color.
interface mpe_rsp_if
   import mpe_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [ITER_W-1:0]  iteration_count;
   logic               inside_set;
   logic [COLOR_W-1:0] red;
   logic [COLOR_W-1:0] green;
   logic [COLOR_W-1:0] blue;

   modport source(output valid, iteration_count, inside_set, red, green, blue, input ready);
   modport sink(input valid, iteration_count, inside_set, red, green, blue, output ready);
endinterface

FILE: src/mpe_ctrl.sv
// Sequencer of the pixel engine: mapping, division steps, iteration loop, output.
module mpe_ctrl
   import mpe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FIX,
      ST_ITA,
      ST_ITB,
      ST_OUT
   } state_type;

   state_type            state_ff, state_in;
   logic                 axis_ff, axis_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      axis_in    = axis_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      cmd.axis   = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               axis_in  = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.map_mul = 1'b1;
            div_cnt_in  = '0;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(QUO_W - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.map_done = 1'b1;
            if (!axis_ff) begin
               axis_in  = 1'b1;
               state_in = ST_MUL;
            end else begin
               state_in = ST_ITA;
            end
         end
         ST_ITA: begin
            // check escape and limit, then run the first half of an iteration
            if (status.iter_go) begin
               cmd.iter_a = 1'b1;
               state_in   = ST_ITB;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_ITB: begin
            cmd.iter_b = 1'b1;
            state_in   = ST_ITA;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= 1'b0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: src/mpe_dp.sv
// Datapath of the pixel engine: coordinate mapping, divider, z iteration, color.
module mpe_dp
   import mpe_pkg::*;
(
   input  logic               clock,
   input  cfg_type            cfg,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [POS_W-1:0]   pixel_x,
   input  logic [POS_W-1:0]   pixel_y,
   output logic [ITER_W-1:0]  iteration_count,
   output logic               inside_set,
   output logic [COLOR_W-1:0] red,
   output logic [COLOR_W-1:0] green,
   output logic [COLOR_W-1:0] blue
);

   function automatic logic [3*COLOR_W-1:0] palette_rgb(input logic [PAL_IDX_W-1:0] idx);
      logic [3*COLOR_W-1:0] rgb;
      unique case (idx)
         4'd0:    rgb = {8'd66,  8'd30,  8'd16};
         4'd1:    rgb = {8'd25,  8'd7,   8'd26};
         4'd2:    rgb = {8'd9,   8'd1,   8'd47};
         4'd3:    rgb = {8'd4,   8'd4,   8'd73};
         4'd4:    rgb = {8'd0,   8'd7,   8'd100};
         4'd5:    rgb = {8'd12,  8'd44,  8'd138};
         4'd6:    rgb = {8'd24,  8'd82,  8'd177};
         4'd7:    rgb = {8'd57,  8'd125, 8'd209};
         4'd8:    rgb = {8'd134, 8'd181, 8'd229};
         4'd9:    rgb = {8'd211, 8'd236, 8'd248};
         4'd10:   rgb = {8'd241, 8'd233, 8'd191};
         4'd11:   rgb = {8'd248, 8'd201, 8'd95};
         4'd12:   rgb = {8'd255, 8'd170, 8'd0};
         4'd13:   rgb = {8'd204, 8'd128, 8'd0};
         4'd14:   rgb = {8'd153, 8'd87,  8'd0};
         default: rgb = {8'd106, 8'd52,  8'd3};
      endcase
      return rgb;
   endfunction

   localparam int SUM_W = QUO_W + 2;

   // pixel and mapping registers
   logic [POS_W-1:0]          px_ff, py_ff;
   logic [QUO_W-1:0]          dq_ff, dq_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic                      neg_ff;
   logic signed [COORD_W-1:0] cx_ff, cy_ff;

   // iteration registers
   logic signed [Z_W-1:0]     x_ff, y_ff, x_in, y_in;
   logic [SQ_W-1:0]           x2_ff, y2_ff, x2_in, y2_in;
   logic [ITER_W-1:0]         count_ff;

   // output register
   logic [ITER_W-1:0]         out_count_ff;
   logic                      out_inside_ff;
   logic [3*COLOR_W-1:0]      out_rgb_ff;

   // mapping logic
   logic [POS_W-1:0]          pos;
   logic signed [COORD_W-1:0] lo, hi;
   logic [SIZE_W-1:0]         size_raw, size_eff;
   logic signed [COORD_W:0]   span;
   logic                      span_neg;
   logic [SPAN_W-1:0]         span_mag;
   logic [QUO_W-1:0]          prod_mag;
   logic [SIZE_W-1:0]         trial;
   logic                      trial_ge;
   logic [QUO_W-1:0]          q_mag;
   logic signed [QUO_W:0]     q_signed;
   logic signed [SUM_W-1:0]   coord_sum;
   logic signed [COORD_W-1:0] coord_sat;

   // iteration logic
   logic signed [PROD_W-1:0]  prod_a, prod_b;
   logic [SQ_W:0]             mag_sum;
   logic                      inside_now;

   assign pos      = cmd.axis ? py_ff : px_ff;
   assign lo       = cmd.axis ? $signed(cfg.imag_min) : $signed(cfg.real_min);
   assign hi       = cmd.axis ? $signed(cfg.imag_max) : $signed(cfg.real_max);
   assign size_raw = cmd.axis ? cfg.screen_height : cfg.screen_width;
   assign size_eff = (size_raw > SIZE_W'(MAX_SIDE)) ? SIZE_W'(MAX_SIDE) : size_raw;

   assign span     = (COORD_W + 1)'(hi) - (COORD_W + 1)'(lo);
   assign span_neg = span[COORD_W];
   assign span_mag = span_neg ? SPAN_W'(~span + 1'b1) : SPAN_W'(span);
   assign prod_mag = {{(QUO_W - POS_W){1'b0}}, pos} * {{(QUO_W - SPAN_W){1'b0}}, span_mag};

   // one restoring division step: shift in the next dividend bit, subtract if it fits
   assign trial    = {rem_ff, dq_ff[QUO_W-1]};
   assign trial_ge = (trial >= size_eff);
   assign rem_in   = trial_ge ? REM_W'(trial - size_eff) : REM_W'(trial);
   assign dq_in    = {dq_ff[QUO_W-2:0], trial_ge};

   // a zero size leaves the coordinate at the min register
   assign q_mag     = (size_eff == '0) ? '0 : dq_ff;
   assign q_signed  = neg_ff ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
   assign coord_sum = SUM_W'(lo) + SUM_W'(q_signed);

   always_comb begin
      if (coord_sum[SUM_W-1:COORD_W-1] == '0 || coord_sum[SUM_W-1:COORD_W-1] == '1) begin
         coord_sat = coord_sum[COORD_W-1:0];
      end else if (coord_sum[SUM_W-1]) begin
         coord_sat = {1'b1, {(COORD_W - 1){1'b0}}};
      end else begin
         coord_sat = {1'b0, {(COORD_W - 1){1'b1}}};
      end
   end

   // first half forms x*y, second half forms x*x and y*y
   assign prod_a = x_ff * (cmd.iter_b ? x_ff : y_ff);
   assign prod_b = y_ff * y_ff;

   assign y_in  = Z_W'(prod_a >>> (FRAC_BITS - 1)) + Z_W'(cy_ff);
   assign x_in  = Z_W'(x2_ff) - Z_W'(y2_ff) + Z_W'(cx_ff);
   assign x2_in = SQ_W'(prod_a >>> FRAC_BITS);
   assign y2_in = SQ_W'(prod_b >>> FRAC_BITS);

   assign mag_sum        = {1'b0, x2_ff} + {1'b0, y2_ff};
   assign status.iter_go = (mag_sum <= ESC_LIMIT) && (count_ff < cfg.max_iterations);
   assign inside_now     = (count_ff >= cfg.max_iterations);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff    <= pixel_x;
         py_ff    <= pixel_y;
         x_ff     <= '0;
         y_ff     <= '0;
         x2_ff    <= '0;
         y2_ff    <= '0;
         count_ff <= '0;
      end
      if (cmd.map_mul) begin
         dq_ff  <= prod_mag;
         rem_ff <= '0;
         neg_ff <= span_neg;
      end
      if (cmd.div_step) begin
         dq_ff  <= dq_in;
         rem_ff <= rem_in;
      end
      if (cmd.map_done) begin
         if (cmd.axis) begin
            cy_ff <= coord_sat;
         end else begin
            cx_ff <= coord_sat;
         end
      end
      if (cmd.iter_a) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
      if (cmd.iter_b) begin
         x2_ff    <= x2_in;
         y2_ff    <= y2_in;
         count_ff <= count_ff + 1'b1;
      end
      if (cmd.out_load) begin
         out_count_ff  <= count_ff;
         out_inside_ff <= inside_now;
         out_rgb_ff    <= inside_now ? '0 : palette_rgb(count_ff[PAL_IDX_W-1:0]);
      end
   end

   assign iteration_count = out_count_ff;
   assign inside_set      = out_inside_ff;
   assign red             = out_rgb_ff[3*COLOR_W-1:2*COLOR_W];
   assign green           = out_rgb_ff[2*COLOR_W-1:COLOR_W];
   assign blue            = out_rgb_ff[COLOR_W-1:0];

endmodule

FILE: src/mandelbrot_pixel_engine.sv
// Top level of the Mandelbrot pixel engine: register file, sequencer and datapath.
//
//   channel   direction  handshake             payload
//   req_chan  in         valid / ready         pixel_x, pixel_y
//   rsp_chan  out        valid / ready         iteration_count, inside_set, red, green, blue
//   csr_*     in         csr_write_en (no wait) csr_index, csr_data
//
// One pixel at a time: accept, then coordinate mapping of each axis in turn through
// the one-bit-per-cycle divider used for both axes (multiply, division steps, saturating
// add), then two halves per iteration of the shared z*z + c unit, one final escape
// check and the output load, which holds while the output register is still full.
// Synchronous active-high reset restores the register defaults and idles the engine.
// A result waits in the output register; the next pixel is accepted meanwhile and
// finishes its work, then holds until that register is taken.
module mandelbrot_pixel_engine
   import mpe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   mpe_req_if.sink               req_chan,
   mpe_rsp_if.source             rsp_chan
);

   localparam cfg_type CFG_RESET = '{
      screen_width:   SIZE_W'(1200),
      screen_height:  SIZE_W'(800),
      max_iterations: ITER_W'(400),
      real_min:       COORD_W'(-536870912),
      real_max:       COORD_W'(126164746),
      imag_min:       COORD_W'(-300647711),
      imag_max:       COORD_W'(300647711)
   };

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_SCREEN_WIDTH:   cfg_in.screen_width   = csr_data[SIZE_W-1:0];
            REG_SCREEN_HEIGHT:  cfg_in.screen_height  = csr_data[SIZE_W-1:0];
            REG_MAX_ITERATIONS: cfg_in.max_iterations = csr_data[ITER_W-1:0];
            REG_REAL_MIN:       cfg_in.real_min       = csr_data[COORD_W-1:0];
            REG_REAL_MAX:       cfg_in.real_max       = csr_data[COORD_W-1:0];
            REG_IMAG_MIN:       cfg_in.imag_min       = csr_data[COORD_W-1:0];
            REG_IMAG_MAX:       cfg_in.imag_max       = csr_data[COORD_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mpe_dp u_dp (
      .clock           (clock),
      .cfg             (cfg_ff),
      .cmd             (cmd),
      .status          (status),
      .pixel_x         (req_chan.pixel_x),
      .pixel_y         (req_chan.pixel_y),
      .iteration_count (rsp_chan.iteration_count),
      .inside_set      (rsp_chan.inside_set),
      .red             (rsp_chan.red),
      .green           (rsp_chan.green),
      .blue            (rsp_chan.blue)
   );

endmodule

FILE: tb/mandelbrot_pixel_engine_tb.sv
// Self-checking testbench of the Mandelbrot pixel engine: directed script, then random views.
`timescale 1ns / 100ps

module mandelbrot_pixel_engine_tb;
   import mpe_pkg::*;

   localparam int     RANDOM_VIEWS       = 22;
   localparam int     PIXELS_PER_VIEW    = 50;
   localparam int     OUTPUT_HOLD_CYCLES = 4000;
   localparam int     SETTLE_CYCLES      = 1000;
   localparam longint COORD_TOP          = 2147483647;
   localparam longint COORD_BOTTOM       = -COORD_TOP - 1;

   typedef struct packed {
      logic [ITER_W-1:0]  count;
      logic               in_set;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } pixel_shade_type;

   typedef struct {
      bit                 is_write;
      csr_reg_type        sel;
      logic [31:0]        value;
      logic [POS_W-1:0]   px;
      logic [POS_W-1:0]   py;
      bit                 known;
      pixel_shade_type    shade;
   } plot_row_type;

   typedef enum {PACE_OPEN, PACE_COIN, PACE_SPARSE, PACE_PERIODIC} pace_mode_type;

   localparam pixel_shade_type NO_SHADE      = '0;
   localparam pixel_shade_type ESCAPED_FIRST = '{12'd1, 1'b0, 8'd25, 8'd7, 8'd26};

   logic clock = 1'b0;
   logic reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   mpe_req_if req_chan();
   mpe_rsp_if rsp_chan();

   mandelbrot_pixel_engine DUT (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic [23:0] palette_rgb [PALETTE_SIZE] = '{
      24'h421E10, 24'h19071A, 24'h09012F, 24'h040449,
      24'h000764, 24'h0C2C8A, 24'h1852B1, 24'h397DD1,
      24'h86B5E5, 24'hD3ECF8, 24'hF1E9BF, 24'hF8C95F,
      24'hFFAA00, 24'hCC8000, 24'h995700, 24'h6A3403
   };

   cfg_type         view;
   pixel_shade_type colors_due [$];
   plot_row_type    plot_script [$];
   int              mismatches = 0;
   int              burst_left = 0;
   bit              hold_results_req = 1'b0;

   // ---------------------------------------------------------------- predictor

   function automatic int plane_coord(logic [POS_W-1:0] pos, logic [SIZE_W-1:0] size,
                                      int lo, int hi);
      longint span, quot, side, sum;
      span = longint'(hi) - longint'(lo);
      side = (size > MAX_SIDE) ? MAX_SIDE : size;
      quot = 0;
      if (side != 0) quot = (longint'(pos) * span) / side;
      sum = longint'(lo) + quot;
      if (sum > COORD_TOP) sum = COORD_TOP;
      if (sum < COORD_BOTTOM) sum = COORD_BOTTOM;
      return int'(sum);
   endfunction

   // floor(a*b / 2^shift) on the exact product
   function automatic longint fixed_mul_floor(longint a, longint b, int shift);
      logic signed [127:0] wide;
      wide = a;
      wide = wide * b;
      return longint'(wide >>> shift);
   endfunction

   function automatic pixel_shade_type shade_of_pixel(logic [POS_W-1:0] px,
                                                      logic [POS_W-1:0] py);
      longint          cx, cy, x, y, x2, y2, bound;
      int unsigned     n;
      pixel_shade_type s;
      cx = plane_coord(px, view.screen_width, view.real_min, view.real_max);
      cy = plane_coord(py, view.screen_height, view.imag_min, view.imag_max);
      bound = longint'(4) << FRAC_BITS;
      x = 0; y = 0; x2 = 0; y2 = 0; n = 0;
      while (x2 + y2 <= bound && n < view.max_iterations) begin
         y  = fixed_mul_floor(x, y, FRAC_BITS - 1) + cy;
         x  = x2 - y2 + cx;
         x2 = fixed_mul_floor(x, x, FRAC_BITS);
         y2 = fixed_mul_floor(y, y, FRAC_BITS);
         n++;
      end
      s.count  = n[ITER_W-1:0];
      s.in_set = (n >= view.max_iterations);
      if (s.in_set) {s.red, s.green, s.blue} = '0;
      else {s.red, s.green, s.blue} = palette_rgb[n % PALETTE_SIZE];
      return s;
   endfunction

   // ---------------------------------------------------------------- script rows

   function automatic void row_write(csr_reg_type sel, logic [31:0] value);
      plot_row_type r;
      r = '{1'b1, sel, value, '0, '0, 1'b0, NO_SHADE};
      plot_script.push_back(r);
   endfunction

   function automatic void row_pixel(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                     bit known, pixel_shade_type shade);
      plot_row_type r;
      r = '{1'b0, REG_SCREEN_WIDTH, '0, px, py, known, shade};
      plot_script.push_back(r);
   endfunction

   function automatic logic [SIZE_W-1:0] random_side();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return SIZE_W'($urandom_range(MAX_SIDE + 1, 8191));
         2:       return SIZE_W'(MAX_SIDE);
         3:       return SIZE_W'(1);
         default: return SIZE_W'($urandom_range(2, MAX_SIDE));
      endcase
   endfunction

   function automatic int last_pixel(logic [SIZE_W-1:0] size);
      if (size == 0 || size > MAX_SIDE) return MAX_SIDE - 1;
      return size - 1;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic drain_pixels();
      req_chan.valid <= 1'b0;
      while (colors_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(csr_reg_type sel, logic [31:0] value);
      drain_pixels();
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= sel;
      csr_data     <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (sel)
         REG_SCREEN_WIDTH:   view.screen_width   = value[SIZE_W-1:0];
         REG_SCREEN_HEIGHT:  view.screen_height  = value[SIZE_W-1:0];
         REG_MAX_ITERATIONS: view.max_iterations = value[ITER_W-1:0];
         REG_REAL_MIN:       view.real_min       = value;
         REG_REAL_MAX:       view.real_max       = value;
         REG_IMAG_MIN:       view.imag_min       = value;
         REG_IMAG_MAX:       view.imag_max       = value;
         default: ;
      endcase
   endtask

   task automatic offer_pixel(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                              bit known, pixel_shade_type shade);
      int gap;
      req_chan.valid   <= 1'b1;
      req_chan.pixel_x <= px;
      req_chan.pixel_y <= py;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      colors_due.push_back(known ? shade : shade_of_pixel(px, py));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         // end of burst: drop valid for a short or a long gap
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 6);
         burst_left = $urandom_range(0, 12);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // ---------------------------------------------------------------- result side

   initial begin : output_pacing
      pace_mode_type mode;
      int            mode_left, hold_left, tick;
      mode = PACE_OPEN;
      mode_left = 0;
      hold_left = 0;
      tick = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_results_req) begin
            hold_results_req = 1'b0;
            hold_left = OUTPUT_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = pace_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(64, 512);
            end
            mode_left--;
            case (mode)
               PACE_OPEN:   rsp_chan.ready <= 1'b1;
               PACE_COIN:   rsp_chan.ready <= $urandom_range(0, 1);
               PACE_SPARSE: rsp_chan.ready <= ($urandom_range(0, 7) == 0);
               default:     rsp_chan.ready <= (tick % 32) < 5;
            endcase
         end
      end
   end

   function automatic void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         $error("%s: expected %0d, actual %0d", field, want, got);
      end
   endfunction

   always @(posedge clock) begin : result_check
      pixel_shade_type due;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (colors_due.size() == 0) begin
            mismatches++;
            $error("result with no pixel pending: iteration_count %0d",
                   rsp_chan.iteration_count);
         end else begin
            due = colors_due.pop_front();
            check_field("iteration_count", 32'(due.count), 32'(rsp_chan.iteration_count));
            check_field("inside_set", 32'(due.in_set), 32'(rsp_chan.inside_set));
            check_field("red", 32'(due.red), 32'(rsp_chan.red));
            check_field("green", 32'(due.green), 32'(rsp_chan.green));
            check_field("blue", 32'(due.blue), 32'(rsp_chan.blue));
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      logic [POS_W-1:0] px, py;
      int               re_lo, re_hi, im_lo, im_hi;
      int unsigned      pick;
      logic [ITER_W-1:0] iter_cap;

      reset            <= 1'b1;
      csr_write_en     <= 1'b0;
      csr_index        <= REG_SCREEN_WIDTH;
      csr_data         <= '0;
      req_chan.valid   <= 1'b0;
      req_chan.pixel_x <= '0;
      req_chan.pixel_y <= '0;

      view.screen_width   = 1200;
      view.screen_height  = 800;
      view.max_iterations = 400;
      view.real_min       = -536870912;
      view.real_max       = 126164746;
      view.imag_min       = -300647711;
      view.imag_max       = 300647711;

      // defaults after reset: corner pixel escapes on the first step
      row_pixel(12'd0, 12'd0, 1'b1, ESCAPED_FIRST);
      row_pixel(12'd4095, 12'd4095, 1'b0, NO_SHADE);
      row_pixel(12'd600, 12'd400, 1'b0, NO_SHADE);
      row_pixel(12'd900, 12'd400, 1'b0, NO_SHADE);
      row_pixel(12'hAAA, 12'h555, 1'b0, NO_SHADE);
      row_pixel(12'h555, 12'hAAA, 1'b0, NO_SHADE);
      // zero iteration limit: no step runs, black
      row_write(REG_MAX_ITERATIONS, 32'd0);
      row_pixel(12'd600, 12'd400, 1'b1, '{12'd0, 1'b1, 8'd0, 8'd0, 8'd0});
      // limit of one: escape and limit coincide, counts as in the set
      row_write(REG_MAX_ITERATIONS, 32'd1);
      row_pixel(12'd0, 12'd0, 1'b1, '{12'd1, 1'b1, 8'd0, 8'd0, 8'd0});
      // origin never escapes: full limit
      row_write(REG_MAX_ITERATIONS, 32'd4095);
      row_write(REG_REAL_MIN, 32'd0);
      row_write(REG_IMAG_MIN, 32'd0);
      row_pixel(12'd0, 12'd0, 1'b1, '{12'd4095, 1'b1, 8'd0, 8'd0, 8'd0});
      // zero sizes pin the point to the min corner
      row_write(REG_SCREEN_WIDTH, 32'd0);
      row_write(REG_SCREEN_HEIGHT, 32'd0);
      row_write(REG_MAX_ITERATIONS, 32'd7);
      row_pixel(12'd4095, 12'd4095, 1'b1, '{12'd7, 1'b1, 8'd0, 8'd0, 8'd0});
      // oversized sizes and full-range window
      row_write(REG_SCREEN_WIDTH, 32'd8191);
      row_write(REG_SCREEN_HEIGHT, 32'd4097);
      row_write(REG_REAL_MIN, 32'h8000_0000);
      row_write(REG_REAL_MAX, 32'h7FFF_FFFF);
      row_write(REG_IMAG_MIN, 32'h7FFF_FFFF);
      row_write(REG_IMAG_MAX, 32'h8000_0000);
      row_write(REG_MAX_ITERATIONS, 32'd20);
      row_pixel(12'd0, 12'd0, 1'b1, ESCAPED_FIRST);
      row_pixel(12'd4095, 12'd4095, 1'b0, NO_SHADE);
      row_pixel(12'd2048, 12'd2048, 1'b0, NO_SHADE);
      // one-pixel screen: extrapolation saturates both ways
      row_write(REG_SCREEN_WIDTH, 32'd1);
      row_write(REG_SCREEN_HEIGHT, 32'd1);
      row_write(REG_REAL_MIN, 32'h4000_0000);
      row_write(REG_REAL_MAX, 32'h7FFF_FFFF);
      row_write(REG_IMAG_MIN, 32'hC000_0000);
      row_write(REG_IMAG_MAX, 32'h8000_0000);
      row_pixel(12'd4095, 12'd0, 1'b1, ESCAPED_FIRST);
      row_pixel(12'd0, 12'd4095, 1'b1, ESCAPED_FIRST);
      row_pixel(12'd1, 12'd1, 1'b0, NO_SHADE);
      // largest regular screen over the default window
      row_write(REG_SCREEN_WIDTH, MAX_SIDE);
      row_write(REG_SCREEN_HEIGHT, MAX_SIDE);
      row_write(REG_MAX_ITERATIONS, 32'd64);
      row_write(REG_REAL_MIN, -536870912);
      row_write(REG_REAL_MAX, 126164746);
      row_write(REG_IMAG_MIN, -300647711);
      row_write(REG_IMAG_MAX, 300647711);
      row_pixel(12'd4095, 12'd0, 1'b0, NO_SHADE);
      row_pixel(12'd0, 12'd4095, 1'b0, NO_SHADE);
      row_pixel(12'd2048, 12'd2048, 1'b0, NO_SHADE);
      row_pixel(12'd3000, 12'd1700, 1'b0, NO_SHADE);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plot_script[i]) begin
         if (plot_script[i].is_write)
            write_reg(plot_script[i].sel, plot_script[i].value);
         else
            offer_pixel(plot_script[i].px, plot_script[i].py, plot_script[i].known,
                        plot_script[i].shade);
      end

      for (int v = 0; v < RANDOM_VIEWS; v++) begin
         write_reg(REG_SCREEN_WIDTH, 32'(random_side()));
         write_reg(REG_SCREEN_HEIGHT, 32'(random_side()));
         // keep the limit low on most views to bound the run
         pick = $urandom_range(0, 19);
         if (pick == 0) iter_cap = ITER_W'(0);
         else if (pick == 1) iter_cap = ITER_W'(400);
         else if (pick < 6) iter_cap = ITER_W'($urandom_range(33, 255));
         else iter_cap = ITER_W'($urandom_range(1, 32));
         write_reg(REG_MAX_ITERATIONS, 32'(iter_cap));
         if ($urandom_range(0, 3) != 0) begin
            // window near the set, Q4.28
            re_lo = int'($urandom_range(0, 805306368)) - 671088640;
            re_hi = re_lo + int'($urandom_range(1 << 20, 939524096));
            im_lo = int'($urandom_range(0, 671088640)) - 402653184;
            im_hi = im_lo + int'($urandom_range(1 << 20, 805306368));
         end else begin
            re_lo = $urandom();
            re_hi = $urandom();
            im_lo = $urandom();
            im_hi = $urandom();
         end
         write_reg(REG_REAL_MIN, re_lo);
         write_reg(REG_REAL_MAX, re_hi);
         write_reg(REG_IMAG_MIN, im_lo);
         write_reg(REG_IMAG_MAX, im_hi);

         for (int k = 0; k < PIXELS_PER_VIEW; k++) begin
            if (v == 2 && k == 8) hold_results_req = 1'b1;
            if (v == 5 && k == 25) drain_pixels();
            if ($urandom_range(0, 7) == 0) begin
               px = POS_W'($urandom_range(0, MAX_SIDE - 1));
               py = POS_W'($urandom_range(0, MAX_SIDE - 1));
            end else begin
               px = POS_W'($urandom_range(0, last_pixel(view.screen_width)));
               py = POS_W'($urandom_range(0, last_pixel(view.screen_height)));
            end
            offer_pixel(px, py, 1'b0, NO_SHADE);
         end
      end

      drain_pixels();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("mandelbrot_pixel_engine_tb: PASS");
      else
         $display("mandelbrot_pixel_engine_tb: FAIL");
      $finish;
   end

   initial begin : watchdog
      #20ms;
      $display("mandelbrot_pixel_engine_tb: FAIL");
      $finish;
   end

endmodule
